/* hw/rtl/skj_pkg.sv */
package skj_pkg;

  localparam int unsigned NROUND = 32;
  localparam int unsigned NSTG   = 2 * NROUND;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // payload carried from stage to stage; w[i] is word i, g is the word under permutation
  typedef struct packed {
    logic              dec;
    logic [3:0][15:0]  w;
    logic [15:0]       g;
  } sd_t;

  localparam logic [0:255][7:0] FTAB = {
    8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
    8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
    8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
    8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
    8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
    8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
    8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
    8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
    8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
    8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
    8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
    8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
    8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
    8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
    8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
    8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
  };

  function automatic logic [7:0] fbox(input logic [7:0] x);
    return FTAB[x];
  endfunction

endpackage

/* hw/rtl/skj_stage.sv */
module skj_stage #(
  parameter int unsigned ROUND = 0,
  parameter bit          HALF  = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_i,
  input  skj_pkg::sd_t     data_i,
  input  logic [79:0]      key_i,
  output logic             valid_o,
  output skj_pkg::sd_t     data_o
);

  localparam int unsigned KE = ROUND;
  localparam int unsigned KD = skj_pkg::NROUND - 1 - ROUND;

  // key byte positions; decrypt walks the g steps backwards
  localparam int unsigned KE_A = (4 * KE + (HALF ? 2 : 0)) % 10;
  localparam int unsigned KE_B = (4 * KE + (HALF ? 3 : 1)) % 10;
  localparam int unsigned KD_A = (4 * KD + (HALF ? 1 : 3)) % 10;
  localparam int unsigned KD_B = (4 * KD + (HALF ? 0 : 2)) % 10;

  localparam logic RA_E = ((KE >> 3) & 1) == 0;
  localparam logic RA_D = ((KD >> 3) & 1) == 0;
  localparam logic [15:0] CTR_E = 16'(KE + 1);
  localparam logic [15:0] CTR_D = 16'(KD + 1);

  logic          valid_r;
  skj_pkg::sd_t  data_r;
  skj_pkg::sd_t  data_nxt;

  logic          dec;
  logic [7:0]    kb_a;
  logic [7:0]    kb_b;
  logic [15:0]   src;
  logic [7:0]    x0;
  logic [7:0]    y0;
  logic [7:0]    y1;
  logic [7:0]    x1;
  logic [15:0]   gres;
  logic          rule_a;
  logic [15:0]   ctr;

  always_comb begin
    dec    = data_i.dec;
    kb_a   = dec ? key_i[8*KD_A +: 8] : key_i[8*KE_A +: 8];
    kb_b   = dec ? key_i[8*KD_B +: 8] : key_i[8*KE_B +: 8];
    src    = HALF ? data_i.g : (dec ? data_i.w[1] : data_i.w[0]);
    // encrypt starts from the low byte, decrypt from the high byte
    x0     = dec ? src[15:8] : src[7:0];
    y0     = dec ? src[7:0] : src[15:8];
    y1     = y0 ^ skj_pkg::fbox(x0 ^ kb_a);
    x1     = x0 ^ skj_pkg::fbox(y1 ^ kb_b);
    gres   = dec ? {x1, y1} : {y1, x1};
    rule_a = dec ? RA_D : RA_E;
    ctr    = dec ? CTR_D : CTR_E;

    data_nxt   = data_i;
    data_nxt.g = gres;
    if (HALF) begin
      if (!dec) begin
        data_nxt.w[3] = data_i.w[2];
        data_nxt.w[1] = gres;
        if (rule_a) begin
          data_nxt.w[2] = data_i.w[1];
          data_nxt.w[0] = data_i.w[3] ^ gres ^ ctr;
        end else begin
          data_nxt.w[2] = data_i.w[0] ^ data_i.w[1] ^ ctr;
          data_nxt.w[0] = data_i.w[3];
        end
      end else begin
        data_nxt.w[0] = gres;
        data_nxt.w[2] = data_i.w[3];
        if (rule_a) begin
          data_nxt.w[1] = data_i.w[2];
          data_nxt.w[3] = data_i.w[0] ^ data_i.w[1] ^ ctr;
        end else begin
          data_nxt.w[1] = gres ^ data_i.w[2] ^ ctr;
          data_nxt.w[3] = data_i.w[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

/* hw/rtl/skipjack_block_cipher.sv */
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall  | in_cmd, in_block_in
// out     | output    | out_valid / out_stall| out_block_out
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one block per cycle unless out_stall holds a result; out_valid rises once its beat has passed every stage
// each of the 32 rounds spans two stages, two dependent f-table lookups per stage
// reset clears every stage valid bit and both key registers
// a result held by out_stall freezes the whole pipeline, and in_stall rises with it
module skipjack_block_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [63:0]                       in_block_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [63:0]                       out_block_out,
  input  logic                              cfg_we,
  input  logic [skj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);

  localparam int unsigned NSTG = skj_pkg::NSTG;

  logic [63:0]          key_low_r;
  logic [15:0]          key_high_r;
  logic [79:0]          key;
  logic                 adv;
  logic [NSTG:0]        stg_valid;
  skj_pkg::sd_t         sd [NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        skj_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
        skj_pkg::REG_KEY_HIGH: key_high_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign key = {key_high_r, key_low_r};

  assign adv      = !(stg_valid[NSTG] && out_stall);
  assign in_stall = !adv;

  assign stg_valid[0] = in_valid;
  assign sd[0].dec    = in_cmd;
  assign sd[0].w[0]   = in_block_in[63:48];
  assign sd[0].w[1]   = in_block_in[47:32];
  assign sd[0].w[2]   = in_block_in[31:16];
  assign sd[0].w[3]   = in_block_in[15:0];
  assign sd[0].g      = '0;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    skj_stage #(
      .ROUND (s / 2),
      .HALF  (1'(s % 2))
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_i (stg_valid[s]),
      .data_i  (sd[s]),
      .key_i   (key),
      .valid_o (stg_valid[s+1]),
      .data_o  (sd[s+1])
    );
  end

  assign out_valid     = stg_valid[NSTG];
  assign out_block_out = {sd[NSTG].w[0], sd[NSTG].w[1], sd[NSTG].w[2], sd[NSTG].w[3]};

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (stg_valid[NSTG:1] == '0))
    else $error("pipeline not empty after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> stg_valid[1])
    else $error("accepted beat did not enter first stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(stg_valid[NSTG:1]))
    else $error("pipeline moved while result stalled");

endmodule
